>>> rtl/ccm_pkg.sv
package ccm_pkg;

    localparam int MAX_PAYLOAD = 2304;
    localparam logic [15:0] AAD_LEN_LIMIT = 16'hff00;
    localparam logic [4:0] TAG_LEN_MIN = 5'd4;
    localparam logic [4:0] TAG_LEN_MAX = 5'd16;
    localparam logic [3:0] NONCE_LEN_MIN = 4'd7;
    localparam logic [3:0] NONCE_LEN_MAX = 4'd13;
    localparam logic [3:0] LEN_FIELD_BASE = 4'd14;

    // byte 0 is the most significant byte of the 128-bit word
    typedef logic [0:15][7:0] blk_t;
    typedef logic [0:12][7:0] nonce_t;

    typedef enum logic [1:0] {OP_START, OP_AAD, OP_PAYLOAD, OP_RELEASE} op_t;
    typedef enum logic [1:0] {KIND_CT, KIND_STATUS, KIND_REL} kind_t;
    typedef enum logic [1:0] {ST_OK, ST_AUTH_FAIL, ST_BAD_CFG, ST_SEQ} status_t;
    typedef enum logic [1:0] {PH_IDLE, PH_AAD, PH_PAYLOAD, PH_RELEASE} phase_t;
    typedef enum logic [2:0] {
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3,
        CFG_KEY_SIZE, CFG_DECRYPT, CFG_TAG_LEN, CFG_NONCE_LEN
    } cfg_idx_t;
    typedef enum logic [1:0] {ENC_B0, ENC_MAC, ENC_CTR, ENC_CTR0} enc_sel_t;
    typedef enum logic [2:0] {OUT_CT, OUT_TAG, OUT_REL, OUT_ERR_SEQ, OUT_ERR_CFG} out_sel_t;
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_KEYX, S_B0_WAIT, S_CTR_WAIT, S_PAY, S_POST,
        S_MAC_WAIT, S_END, S_TAG_WAIT, S_REL, S_OUT
    } ctl_state_t;

    typedef struct packed {
        logic     capture;
        logic     setup;
        logic     enc_start;
        enc_sel_t enc_sel;
        logic     mac_set;
        logic     buf_clear;
        logic     ks_load;
        logic     aad_byte;
        logic     pay_byte;
        logic     set_phase;
        phase_t   phase_val;
        logic     out_load;
        out_sel_t out_sel;
        logic     rel_read;
    } ccm_cmd_t;

    typedef struct packed {
        op_t    op;
        logic   bad_cfg;
        phase_t phase;
        logic   aad_rem_zero;
        logic   pay_rem_zero;
        logic   fill_zero;
        logic   fill_full;
        logic   aes_busy;
        logic   decrypt;
    } ccm_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic blk_t aes_round(blk_t s, blk_t rk, logic last);
        blk_t u;
        blk_t r;
        logic [7:0] a0, a1, a2, a3, all;
        for (int x = 0; x < 16; x++) begin
            u[x] = SBOX[s[x]];
        end
        // shift rows
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                r[w + 4*c] = u[w + 4*((c + w) & 3)];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = r[4*c];
                a1 = r[4*c+1];
                a2 = r[4*c+2];
                a3 = r[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                r[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                r[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                r[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                r[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        return r ^ rk;
    endfunction

endpackage

>>> rtl/ccm_aes.sv
module ccm_aes import ccm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         kx_start,
    input  logic [255:0] key,
    input  logic         key_256,
    input  logic         enc_start,
    input  blk_t         blk_in,
    output logic         busy,
    output blk_t         result
);

    blk_t       rk_reg [15];
    blk_t       p1_reg, p2_reg, st_reg;
    logic [3:0] idx_reg;
    logic       k256_reg;
    logic       kx_run_reg, enc_run_reg;

    logic [3:0]  nr;
    logic [31:0] lastw, temp;
    logic [3:0]  rci;
    blk_t        base, nw;
    logic        copy_step;

    assign nr = k256_reg ? 4'd14 : 4'd10;
    assign busy = kx_run_reg | enc_run_reg;
    assign result = st_reg;
    // second aes-256 round key is the key's low half as is
    assign copy_step = k256_reg && (idx_reg == 4'd1);

    always_comb begin
        lastw = p1_reg[12:15];
        rci = k256_reg ? ({1'b0, idx_reg[3:1]} - 4'd1) : (idx_reg - 4'd1);
        if (!k256_reg || !idx_reg[0]) begin
            temp = sub_word({lastw[23:0], lastw[31:24]}) ^ {RCON[rci], 24'h0};
        end else begin
            temp = sub_word(lastw);
        end
        base = k256_reg ? p2_reg : p1_reg;
        nw[0:3]   = base[0:3] ^ temp;
        nw[4:7]   = base[4:7] ^ nw[0:3];
        nw[8:11]  = base[8:11] ^ nw[4:7];
        nw[12:15] = base[12:15] ^ nw[8:11];
        if (copy_step) begin
            nw = p1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kx_run_reg  <= 1'b0;
            enc_run_reg <= 1'b0;
        end else begin
            if (kx_start) begin
                kx_run_reg <= 1'b1;
            end else if (kx_run_reg && idx_reg == nr) begin
                kx_run_reg <= 1'b0;
            end
            if (enc_start) begin
                enc_run_reg <= 1'b1;
            end else if (enc_run_reg && idx_reg == nr) begin
                enc_run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (kx_start) begin
            k256_reg  <= key_256;
            rk_reg[0] <= key[255:128];
            p2_reg    <= key[255:128];
            p1_reg    <= key_256 ? key[127:0] : key[255:128];
            idx_reg   <= 4'd1;
        end else if (enc_start) begin
            st_reg  <= blk_in ^ rk_reg[0];
            idx_reg <= 4'd1;
        end else if (kx_run_reg) begin
            rk_reg[idx_reg] <= nw;
            if (!copy_step) begin
                p2_reg <= p1_reg;
                p1_reg <= nw;
            end
            idx_reg <= idx_reg + 4'd1;
        end else if (enc_run_reg) begin
            st_reg  <= aes_round(st_reg, rk_reg[idx_reg], idx_reg == nr);
            idx_reg <= idx_reg + 4'd1;
        end
    end

endmodule

>>> rtl/ccm_ctrl.sv
module ccm_ctrl import ccm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  ccm_status_t st,
    output ccm_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic       cont_reg;
    logic       rem_zero, flush, done_aad, finish;
    logic       aad_err, pay_err;

    always_comb begin
        rem_zero = (st.phase == PH_AAD) ? st.aad_rem_zero : st.pay_rem_zero;
        flush    = st.fill_full || (rem_zero && !st.fill_zero);
        done_aad = (st.phase == PH_AAD) && st.aad_rem_zero;
        finish   = (done_aad && st.pay_rem_zero)
                || ((st.phase == PH_PAYLOAD) && st.pay_rem_zero);
        aad_err  = (st.phase != PH_AAD) || st.aad_rem_zero;
        pay_err  = (st.phase != PH_PAYLOAD) || st.pay_rem_zero;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_DECODE;
            S_DECODE: begin
                unique case (st.op)
                    OP_START:   state_next = st.bad_cfg ? S_OUT : S_KEYX;
                    OP_AAD:     state_next = aad_err ? S_OUT : S_POST;
                    OP_PAYLOAD: state_next = pay_err ? S_OUT
                                           : (st.fill_zero ? S_CTR_WAIT : S_PAY);
                    OP_RELEASE: state_next = (st.phase != PH_RELEASE) ? S_OUT : S_REL;
                endcase
            end
            S_KEYX: if (!st.aes_busy) state_next = S_B0_WAIT;
            S_B0_WAIT: begin
                if (!st.aes_busy) begin
                    state_next = (st.aad_rem_zero && st.pay_rem_zero) ? S_TAG_WAIT : S_IDLE;
                end
            end
            S_CTR_WAIT: if (!st.aes_busy) state_next = S_PAY;
            S_PAY:      state_next = st.decrypt ? S_POST : S_OUT;
            S_POST:     state_next = flush ? S_MAC_WAIT : S_END;
            S_MAC_WAIT: if (!st.aes_busy) state_next = S_END;
            S_END:      state_next = finish ? S_TAG_WAIT : S_IDLE;
            S_TAG_WAIT: if (!st.aes_busy) state_next = S_OUT;
            S_REL:      state_next = S_OUT;
            S_OUT:      if (m_ready) state_next = cont_reg ? S_POST : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE: cmd.capture = s_valid;
            S_DECODE: begin
                unique case (st.op)
                    OP_START: begin
                        if (st.bad_cfg) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ERR_CFG;
                        end else begin
                            cmd.setup = 1'b1;
                        end
                    end
                    OP_AAD: begin
                        if (aad_err) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ERR_SEQ;
                        end else begin
                            cmd.aad_byte = 1'b1;
                        end
                    end
                    OP_PAYLOAD: begin
                        if (pay_err) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ERR_SEQ;
                        end else if (st.fill_zero) begin
                            cmd.enc_start = 1'b1;
                            cmd.enc_sel   = ENC_CTR;
                        end
                    end
                    OP_RELEASE: begin
                        if (st.phase != PH_RELEASE) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ERR_SEQ;
                        end else begin
                            cmd.rel_read = 1'b1;
                        end
                    end
                endcase
            end
            S_KEYX: begin
                if (!st.aes_busy) begin
                    cmd.enc_start = 1'b1;
                    cmd.enc_sel   = ENC_B0;
                end
            end
            S_B0_WAIT: begin
                if (!st.aes_busy) begin
                    cmd.mac_set = 1'b1;
                    if (!st.aad_rem_zero) begin
                        cmd.set_phase = 1'b1;
                        cmd.phase_val = PH_AAD;
                    end else if (st.pay_rem_zero) begin
                        cmd.enc_start = 1'b1;
                        cmd.enc_sel   = ENC_CTR0;
                    end else begin
                        cmd.set_phase = 1'b1;
                        cmd.phase_val = PH_PAYLOAD;
                    end
                end
            end
            S_CTR_WAIT: cmd.ks_load = !st.aes_busy;
            S_PAY: begin
                cmd.pay_byte = 1'b1;
                cmd.out_load = !st.decrypt;
                cmd.out_sel  = OUT_CT;
            end
            S_POST: begin
                cmd.enc_start = flush;
                cmd.enc_sel   = ENC_MAC;
            end
            S_MAC_WAIT: begin
                cmd.mac_set   = !st.aes_busy;
                cmd.buf_clear = !st.aes_busy;
            end
            S_END: begin
                if (finish) begin
                    cmd.enc_start = 1'b1;
                    cmd.enc_sel   = ENC_CTR0;
                end else if (done_aad) begin
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = PH_PAYLOAD;
                end
            end
            S_TAG_WAIT: begin
                cmd.out_load = !st.aes_busy;
                cmd.out_sel  = OUT_TAG;
            end
            S_REL: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_REL;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cont_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            // after a ciphertext byte the block flush check still follows
            if (state_next == S_OUT && state_reg != S_OUT) begin
                cont_reg <= (state_reg == S_PAY);
            end
        end
    end

endmodule

>>> rtl/ccm_datapath.sv
module ccm_datapath import ccm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic [1:0]   s_operation,
    input  logic [7:0]   s_data_byte,
    input  logic [63:0]  s_nonce_high,
    input  logic [39:0]  s_nonce_low,
    input  logic [15:0]  s_aad_length,
    input  logic [11:0]  s_payload_length,
    input  logic [63:0]  s_received_tag_high,
    input  logic [63:0]  s_received_tag_low,
    output logic [1:0]   m_result_kind,
    output logic [7:0]   m_out_byte,
    output logic [63:0]  m_tag_high,
    output logic [63:0]  m_tag_low,
    output logic [1:0]   m_status,
    output logic         m_last,
    input  ccm_cmd_t     cmd,
    output ccm_status_t  st
);

    // configuration registers
    logic [63:0] kw0_reg, kw1_reg, kw2_reg, kw3_reg;
    logic        k256_cfg_reg, dec_cfg_reg;
    logic [4:0]  tl_cfg_reg;
    logic [3:0]  nl_cfg_reg;

    // captured request
    op_t         op_reg;
    logic [7:0]  byte_reg;
    logic [63:0] nh_reg, rth_reg, rtl_reg;
    logic [39:0] nlo_reg;
    logic [15:0] al_reg;
    logic [11:0] pl_reg;

    // message state
    logic        lat_dec_reg;
    logic [4:0]  lat_tl_reg;
    logic [3:0]  lat_nl_reg;
    nonce_t      nonce_reg;
    blk_t        tag_reg, mac_reg, buf_reg, ks_reg;
    logic [4:0]  fill_reg;
    logic [11:0] ctr_reg, pay_rem_reg, msg_len_reg, rel_idx_reg;
    logic [15:0] aad_rem_reg;
    logic        verified_reg;
    phase_t      phase_reg;
    logic [7:0]  held_mem [MAX_PAYLOAD];
    logic [7:0]  rd_reg;

    // output register
    kind_t       kind_reg;
    logic [7:0]  obyte_reg;
    logic [63:0] oth_reg, otl_reg;
    status_t     ost_reg;
    logic        olast_reg;

    blk_t        aes_in, aes_res, tg, ctr_blk;
    logic        aes_busy;
    logic [2:0]  lq;
    logic [11:0] ctr_sel;
    logic [7:0]  ptb;
    logic [11:0] wpos;
    logic        tag_ok, rel_last;
    nonce_t      nonce_in;
    blk_t        diff;

    assign lq = 3'(LEN_FIELD_BASE - lat_nl_reg);

    always_comb begin
        ctr_sel = (cmd.enc_sel == ENC_CTR) ? (ctr_reg + 12'd1) : 12'd0;
        ctr_blk = {{5'd0, lq}, nonce_reg, 4'd0, ctr_sel};
        unique case (cmd.enc_sel)
            ENC_B0: aes_in = {{1'b0, (al_reg != 16'd0), 3'(lat_tl_reg[4:1] - 4'd1), lq},
                              nonce_reg, 4'd0, pl_reg};
            ENC_MAC: aes_in = mac_reg ^ buf_reg;
            default: aes_in = ctr_blk;
        endcase
    end

    ccm_aes u_aes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kx_start  (cmd.setup),
        .key       ({kw0_reg, kw1_reg, kw2_reg, kw3_reg}),
        .key_256   (k256_cfg_reg),
        .enc_start (cmd.enc_start),
        .blk_in    (aes_in),
        .busy      (aes_busy),
        .result    (aes_res)
    );

    always_comb begin
        for (int x = 0; x < 8; x++) begin
            nonce_in[x] = (4'(x) < nl_cfg_reg) ? nh_reg[63-8*x -: 8] : 8'd0;
        end
        for (int x = 0; x < 5; x++) begin
            nonce_in[8+x] = (4'(x + 8) < nl_cfg_reg) ? nlo_reg[39-8*x -: 8] : 8'd0;
        end
        for (int x = 0; x < 16; x++) begin
            tg[x] = (5'(x) < lat_tl_reg) ? (mac_reg[x] ^ aes_res[x]) : 8'd0;
        end
        diff = tg ^ tag_reg;
        for (int x = 0; x < 16; x++) begin
            if (5'(x) >= lat_tl_reg) diff[x] = 8'd0;
        end
        tag_ok   = (diff == '0);
        ptb      = byte_reg ^ ks_reg[fill_reg[3:0]];
        wpos     = msg_len_reg - pay_rem_reg;
        rel_last = ({1'b0, rel_idx_reg} + 13'd1) >= {1'b0, msg_len_reg};
    end

    always_comb begin
        st.op           = op_reg;
        st.bad_cfg      = (tl_cfg_reg < TAG_LEN_MIN) || (tl_cfg_reg > TAG_LEN_MAX)
                       || tl_cfg_reg[0] || (nl_cfg_reg < NONCE_LEN_MIN)
                       || (nl_cfg_reg > NONCE_LEN_MAX) || (al_reg >= AAD_LEN_LIMIT)
                       || (pl_reg > 12'(MAX_PAYLOAD));
        st.phase        = phase_reg;
        st.aad_rem_zero = (aad_rem_reg == 16'd0);
        st.pay_rem_zero = (pay_rem_reg == 12'd0);
        st.fill_zero    = (fill_reg == 5'd0);
        st.fill_full    = fill_reg[4];
        st.aes_busy     = aes_busy;
        st.decrypt      = lat_dec_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw0_reg      <= '0;
            kw1_reg      <= '0;
            kw2_reg      <= '0;
            kw3_reg      <= '0;
            k256_cfg_reg <= 1'b0;
            dec_cfg_reg  <= 1'b0;
            tl_cfg_reg   <= 5'd8;
            nl_cfg_reg   <= 4'd13;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY0:      kw0_reg      <= cfg_wdata;
                CFG_KEY1:      kw1_reg      <= cfg_wdata;
                CFG_KEY2:      kw2_reg      <= cfg_wdata;
                CFG_KEY3:      kw3_reg      <= cfg_wdata;
                CFG_KEY_SIZE:  k256_cfg_reg <= cfg_wdata[0];
                CFG_DECRYPT:   dec_cfg_reg  <= cfg_wdata[0];
                CFG_TAG_LEN:   tl_cfg_reg   <= cfg_wdata[4:0];
                CFG_NONCE_LEN: nl_cfg_reg   <= cfg_wdata[3:0];
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            fill_reg     <= '0;
            aad_rem_reg  <= '0;
            pay_rem_reg  <= '0;
            ctr_reg      <= '0;
            msg_len_reg  <= '0;
            rel_idx_reg  <= '0;
            verified_reg <= 1'b0;
        end else begin
            if (cmd.setup) begin
                fill_reg     <= (al_reg != 16'd0) ? 5'd2 : 5'd0;
                aad_rem_reg  <= al_reg;
                pay_rem_reg  <= pl_reg;
                msg_len_reg  <= pl_reg;
                ctr_reg      <= '0;
                rel_idx_reg  <= '0;
                verified_reg <= 1'b0;
            end
            if (cmd.enc_start && cmd.enc_sel == ENC_CTR) begin
                ctr_reg <= ctr_reg + 12'd1;
            end
            if (cmd.aad_byte) begin
                fill_reg    <= fill_reg + 5'd1;
                aad_rem_reg <= aad_rem_reg - 16'd1;
            end
            if (cmd.pay_byte) begin
                fill_reg    <= fill_reg + 5'd1;
                pay_rem_reg <= pay_rem_reg - 12'd1;
            end
            if (cmd.buf_clear) begin
                fill_reg <= '0;
            end
            if (cmd.set_phase) begin
                phase_reg <= cmd.phase_val;
            end
            if (cmd.out_load) begin
                unique case (cmd.out_sel)
                    OUT_TAG: begin
                        rel_idx_reg  <= '0;
                        verified_reg <= lat_dec_reg && tag_ok;
                        phase_reg    <= (lat_dec_reg && msg_len_reg != 12'd0)
                                        ? PH_RELEASE : PH_IDLE;
                    end
                    OUT_REL: begin
                        rel_idx_reg <= rel_idx_reg + 12'd1;
                        if (rel_last) phase_reg <= PH_IDLE;
                    end
                    OUT_ERR_CFG: phase_reg <= PH_IDLE;
                    default: ;
                endcase
            end
        end
    end

    // data registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= op_t'(s_operation);
            byte_reg <= s_data_byte;
            nh_reg   <= s_nonce_high;
            nlo_reg  <= s_nonce_low;
            al_reg   <= s_aad_length;
            pl_reg   <= s_payload_length;
            rth_reg  <= s_received_tag_high;
            rtl_reg  <= s_received_tag_low;
        end
        if (cmd.setup) begin
            lat_dec_reg <= dec_cfg_reg;
            lat_tl_reg  <= tl_cfg_reg;
            lat_nl_reg  <= nl_cfg_reg;
            nonce_reg   <= nonce_in;
            tag_reg     <= {rth_reg, rtl_reg};
            buf_reg     <= (al_reg != 16'd0) ? {al_reg, 112'd0} : '0;
        end
        if (cmd.aad_byte) begin
            buf_reg[fill_reg[3:0]] <= byte_reg;
        end
        if (cmd.pay_byte) begin
            buf_reg[fill_reg[3:0]] <= lat_dec_reg ? ptb : byte_reg;
        end
        if (cmd.buf_clear) begin
            buf_reg <= '0;
        end
        if (cmd.mac_set) begin
            mac_reg <= aes_res;
        end
        if (cmd.ks_load) begin
            ks_reg <= aes_res;
        end
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                OUT_CT: begin
                    kind_reg  <= KIND_CT;
                    obyte_reg <= ptb;
                    oth_reg   <= '0;
                    otl_reg   <= '0;
                    ost_reg   <= ST_OK;
                    olast_reg <= 1'b0;
                end
                OUT_TAG: begin
                    kind_reg  <= KIND_STATUS;
                    obyte_reg <= '0;
                    // a decryption never shows the expected tag
                    oth_reg   <= lat_dec_reg ? 64'd0 : tg[0:7];
                    otl_reg   <= lat_dec_reg ? 64'd0 : tg[8:15];
                    ost_reg   <= (lat_dec_reg && !tag_ok) ? ST_AUTH_FAIL : ST_OK;
                    olast_reg <= 1'b1;
                end
                OUT_REL: begin
                    kind_reg  <= KIND_REL;
                    obyte_reg <= verified_reg ? rd_reg : 8'd0;
                    oth_reg   <= '0;
                    otl_reg   <= '0;
                    ost_reg   <= verified_reg ? ST_OK : ST_AUTH_FAIL;
                    olast_reg <= rel_last;
                end
                OUT_ERR_SEQ: begin
                    kind_reg  <= KIND_STATUS;
                    obyte_reg <= '0;
                    oth_reg   <= '0;
                    otl_reg   <= '0;
                    ost_reg   <= ST_SEQ;
                    olast_reg <= 1'b0;
                end
                default: begin
                    kind_reg  <= KIND_STATUS;
                    obyte_reg <= '0;
                    oth_reg   <= '0;
                    otl_reg   <= '0;
                    ost_reg   <= ST_BAD_CFG;
                    olast_reg <= 1'b1;
                end
            endcase
        end
    end

    // plaintext held for release
    always_ff @(posedge aclk) begin
        if (cmd.pay_byte && lat_dec_reg) begin
            held_mem[wpos] <= ptb;
        end
        if (cmd.rel_read) begin
            rd_reg <= held_mem[rel_idx_reg];
        end
    end

    assign m_result_kind = kind_reg;
    assign m_out_byte    = obyte_reg;
    assign m_tag_high    = oth_reg;
    assign m_tag_low     = otl_reg;
    assign m_status      = ost_reg;
    assign m_last        = olast_reg;

endmodule

>>> rtl/aes_ccm_authenticated_cipher_unit.sv
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_index, cfg_wdata
// s_        in         s_valid / s_ready    operation, nonce, lengths, tag, data byte
// m_        out        m_valid / m_ready    result kind, byte, tag, status, last
//
// one request at a time; one aes round per cycle from a 15-entry round key file
// start: key expansion, then b0 is enciphered; nr = 10 or 14 rounds
// an aad or payload byte takes an extra aes run when a block is
// absorbed or a new keystream block is made; the tag takes another aes run
// synchronous active-low reset; the plaintext store is not cleared
// s_ready is low while a request is worked on or a result waits on m_ready
module aes_ccm_authenticated_cipher_unit import ccm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic [63:0] s_nonce_high,
    input  logic [39:0] s_nonce_low,
    input  logic [15:0] s_aad_length,
    input  logic [11:0] s_payload_length,
    input  logic [63:0] s_received_tag_high,
    input  logic [63:0] s_received_tag_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_out_byte,
    output logic [63:0] m_tag_high,
    output logic [63:0] m_tag_low,
    output logic [1:0]  m_status,
    output logic        m_last
);

    ccm_cmd_t    cmd;
    ccm_status_t st;

    ccm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ccm_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_operation         (s_operation),
        .s_data_byte         (s_data_byte),
        .s_nonce_high        (s_nonce_high),
        .s_nonce_low         (s_nonce_low),
        .s_aad_length        (s_aad_length),
        .s_payload_length    (s_payload_length),
        .s_received_tag_high (s_received_tag_high),
        .s_received_tag_low  (s_received_tag_low),
        .m_result_kind       (m_result_kind),
        .m_out_byte          (m_out_byte),
        .m_tag_high          (m_tag_high),
        .m_tag_low           (m_tag_low),
        .m_status            (m_status),
        .m_last              (m_last),
        .cmd                 (cmd),
        .st                  (st)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken before the first was decoded");

    a_ct_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_CT) |-> !m_last)
        else $error("ciphertext byte marked last");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_REL && m_status == ST_AUTH_FAIL)
        |-> (m_out_byte == 8'd0))
        else $error("plaintext released after failed authentication");

    a_aes_idle_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !st.aes_busy)
        else $error("request taken while the cipher is running");

endmodule

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    import ccm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        op_t         op;
        logic [7:0]  data;
        logic [63:0] nonce_hi;
        logic [39:0] nonce_lo;
        logic [15:0] aad_len;
        logic [11:0] pay_len;
        logic [63:0] rtag_hi;
        logic [63:0] rtag_lo;
    } ccm_req_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [63:0] tag_hi;
        logic [63:0] tag_lo;
        status_t     status;
        logic        last;
    } ccm_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [7:0]  s_data_byte;
    logic [63:0] s_nonce_high;
    logic [39:0] s_nonce_low;
    logic [15:0] s_aad_length;
    logic [11:0] s_payload_length;
    logic [63:0] s_received_tag_high;
    logic [63:0] s_received_tag_low;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_out_byte;
    logic [63:0] m_tag_high;
    logic [63:0] m_tag_low;
    logic [1:0]  m_status;
    logic        m_last;

    aes_ccm_authenticated_cipher_unit u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_data_byte         (s_data_byte),
        .s_nonce_high        (s_nonce_high),
        .s_nonce_low         (s_nonce_low),
        .s_aad_length        (s_aad_length),
        .s_payload_length    (s_payload_length),
        .s_received_tag_high (s_received_tag_high),
        .s_received_tag_low  (s_received_tag_low),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_kind       (m_result_kind),
        .m_out_byte          (m_out_byte),
        .m_tag_high          (m_tag_high),
        .m_tag_low           (m_tag_low),
        .m_status            (m_status),
        .m_last              (m_last)
    );

    ccm_req_t    pending_reqs[$];
    ccm_result_t expected_results[$];
    ccm_req_t    cur_req;
    int          failures;
    int          n_items;
    int          stall_cycles;
    bit          calm;

    // register copies
    logic [63:0] cfg_key [4];
    logic        cfg_key256;
    logic        cfg_decrypt;
    logic [4:0]  cfg_tag_len;
    logic [3:0]  cfg_nonce_len;

    // cipher state
    logic [7:0]  rk [240];
    int          nrounds;
    blk_t        mac_acc;
    blk_t        blk_buf;
    blk_t        ks_blk;
    blk_t        rtag_store;
    logic [7:0]  nonce_bytes [13];
    logic [7:0]  held_pt [MAX_PAYLOAD];
    int          blk_fill;
    logic [11:0] ctr_idx;
    int          aad_rem;
    int          pay_rem;
    int          msg_len;
    logic [11:0] rel_idx;
    bit          verified;
    phase_t      msg_phase;
    bit          lat_decrypt;
    int          lat_tag_len;
    int          lat_nonce_len;

    // ciphertext and tag of the last sealed message, replayed for decryption
    logic [7:0]  sealed_ct[$];
    blk_t        sealed_tag;
    bit          sealed_ok;

    function automatic logic [7:0] gf_double(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void expand_round_keys();
        logic [7:0] t4 [4];
        logic [7:0] f;
        int nk;
        int total;
        nk = cfg_key256 ? 8 : 4;
        nrounds = (nk == 8) ? 14 : 10;
        total = 4 * (nrounds + 1);
        for (int z = 0; z < 4 * nk; z++) begin
            rk[z] = cfg_key[z / 8][63 - 8 * (z % 8) -: 8];
        end
        for (int w = nk; w < total; w++) begin
            for (int k = 0; k < 4; k++) t4[k] = rk[4 * (w - 1) + k];
            if (w % nk == 0) begin
                f = t4[0];
                t4[0] = SBOX[t4[1]] ^ RCON[(w / nk - 1) % 10];
                t4[1] = SBOX[t4[2]];
                t4[2] = SBOX[t4[3]];
                t4[3] = SBOX[f];
            end else if (nk == 8 && w % 8 == 4) begin
                for (int k = 0; k < 4; k++) t4[k] = SBOX[t4[k]];
            end
            for (int k = 0; k < 4; k++) rk[4 * w + k] = rk[4 * (w - nk) + k] ^ t4[k];
        end
    endfunction

    function automatic blk_t cipher_block(blk_t src);
        blk_t s;
        blk_t u;
        logic [7:0] a0, a1, a2, a3, all;
        for (int x = 0; x < 16; x++) s[x] = src[x] ^ rk[x];
        for (int rnd = 1; rnd <= nrounds; rnd++) begin
            for (int x = 0; x < 16; x++) u[x] = SBOX[s[x]];
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) s[r + 4 * c] = u[r + 4 * ((c + r) & 3)];
            end
            if (rnd != nrounds) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c];
                    a1 = s[4 * c + 1];
                    a2 = s[4 * c + 2];
                    a3 = s[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int x = 0; x < 16; x++) s[x] = s[x] ^ rk[16 * rnd + x];
        end
        return s;
    endfunction

    function automatic void mac_absorb(blk_t b);
        mac_acc = cipher_block(mac_acc ^ b);
    endfunction

    function automatic void flush_block();
        if (blk_fill != 0) mac_absorb(blk_buf);
        blk_buf = '0;
        blk_fill = 0;
    endfunction

    function automatic blk_t ctr_block(int idx);
        blk_t b;
        b = '0;
        b[0] = 8'(14 - lat_nonce_len);
        for (int x = 0; x < lat_nonce_len && x < 13; x++) b[1 + x] = nonce_bytes[x];
        b[14] = 8'((idx >> 8) & 8'hff);
        b[15] = 8'(idx & 8'hff);
        return b;
    endfunction

    function automatic void add_result(kind_t k, logic [7:0] b, logic [63:0] th,
                                       logic [63:0] tl, status_t st, logic lst);
        ccm_result_t e;
        e.kind = k;
        e.out_byte = b;
        e.tag_hi = th;
        e.tag_lo = tl;
        e.status = st;
        e.last = lst;
        expected_results.push_back(e);
    endfunction

    function automatic void finish_message();
        blk_t s0;
        blk_t tg;
        logic [127:0] tgw;
        logic [7:0] acc;
        s0 = cipher_block(ctr_block(0));
        for (int x = 0; x < 16; x++) tg[x] = (x < lat_tag_len) ? (mac_acc[x] ^ s0[x]) : 8'h00;
        tgw = tg;
        if (!lat_decrypt) begin
            add_result(KIND_STATUS, 8'h00, tgw[127:64], tgw[63:0], ST_OK, 1'b1);
            sealed_tag = tg;
            sealed_ok = 1'b1;
            msg_phase = PH_IDLE;
            return;
        end
        acc = 8'h00;
        for (int x = 0; x < lat_tag_len; x++) acc = acc | (tg[x] ^ rtag_store[x]);
        verified = (acc == 8'h00);
        if (!verified) begin
            for (int x = 0; x < MAX_PAYLOAD; x++) held_pt[x] = 8'h00;
        end
        add_result(KIND_STATUS, 8'h00, 64'h0, 64'h0, verified ? ST_OK : ST_AUTH_FAIL, 1'b1);
        rel_idx = '0;
        msg_phase = (msg_len > 0) ? PH_RELEASE : PH_IDLE;
    endfunction

    function automatic void after_aad();
        if (pay_rem == 0) finish_message();
        else msg_phase = PH_PAYLOAD;
    endfunction

    function automatic void predict_request(ccm_req_t r);
        blk_t b0;
        int tl;
        int nl;
        int al;
        int pl;
        int pos;
        logic [7:0] ptb;
        case (r.op)
            OP_START: begin
                tl = cfg_tag_len;
                nl = cfg_nonce_len;
                al = r.aad_len;
                pl = r.pay_len;
                if (tl < 4 || tl > 16 || tl % 2 == 1 || nl < 7 || nl > 13 ||
                    al >= AAD_LEN_LIMIT || pl > MAX_PAYLOAD) begin
                    msg_phase = PH_IDLE;
                    add_result(KIND_STATUS, 8'h00, 64'h0, 64'h0, ST_BAD_CFG, 1'b1);
                    return;
                end
                lat_decrypt = cfg_decrypt;
                lat_tag_len = tl;
                lat_nonce_len = nl;
                expand_round_keys();
                for (int x = 0; x < 13; x++) begin
                    if (x >= nl) nonce_bytes[x] = 8'h00;
                    else if (x < 8) nonce_bytes[x] = r.nonce_hi[63 - 8 * x -: 8];
                    else nonce_bytes[x] = r.nonce_lo[39 - 8 * (x - 8) -: 8];
                end
                rtag_store = {r.rtag_hi, r.rtag_lo};
                b0 = ctr_block(pl);
                b0[0] = (al > 0 ? 8'h40 : 8'h00) | 8'(((tl - 2) / 2) << 3) | 8'(14 - nl);
                mac_acc = '0;
                mac_absorb(b0);
                blk_buf = '0;
                blk_fill = 0;
                if (al > 0) begin
                    blk_buf[0] = r.aad_len[15:8];
                    blk_buf[1] = r.aad_len[7:0];
                    blk_fill = 2;
                end
                ks_blk = '0;
                ctr_idx = '0;
                aad_rem = al;
                pay_rem = pl;
                msg_len = pl;
                verified = 1'b0;
                rel_idx = '0;
                if (al > 0) msg_phase = PH_AAD;
                else after_aad();
            end
            OP_AAD: begin
                if (msg_phase != PH_AAD || aad_rem == 0) begin
                    add_result(KIND_STATUS, 8'h00, 64'h0, 64'h0, ST_SEQ, 1'b0);
                    return;
                end
                blk_buf[blk_fill] = r.data;
                blk_fill++;
                if (blk_fill >= 16) flush_block();
                aad_rem--;
                if (aad_rem == 0) begin
                    flush_block();
                    after_aad();
                end
            end
            OP_PAYLOAD: begin
                if (msg_phase != PH_PAYLOAD || pay_rem == 0) begin
                    add_result(KIND_STATUS, 8'h00, 64'h0, 64'h0, ST_SEQ, 1'b0);
                    return;
                end
                if (blk_fill == 0) begin
                    ctr_idx = ctr_idx + 1'b1;
                    ks_blk = cipher_block(ctr_block(ctr_idx));
                end
                ptb = r.data ^ ks_blk[blk_fill];
                pos = msg_len - pay_rem;
                if (lat_decrypt) begin
                    if (pos < MAX_PAYLOAD) held_pt[pos] = ptb;
                    blk_buf[blk_fill] = ptb;
                end else begin
                    blk_buf[blk_fill] = r.data;
                    add_result(KIND_CT, ptb, 64'h0, 64'h0, ST_OK, 1'b0);
                    sealed_ct.push_back(ptb);
                end
                blk_fill++;
                if (blk_fill >= 16) flush_block();
                pay_rem--;
                if (pay_rem == 0) begin
                    flush_block();
                    finish_message();
                end
            end
            default: begin
                if (msg_phase != PH_RELEASE) begin
                    add_result(KIND_STATUS, 8'h00, 64'h0, 64'h0, ST_SEQ, 1'b0);
                    return;
                end
                pos = rel_idx;
                ptb = (verified && pos < MAX_PAYLOAD) ? held_pt[pos] : 8'h00;
                rel_idx = rel_idx + 1'b1;
                if (pos + 1 >= msg_len) msg_phase = PH_IDLE;
                add_result(KIND_REL, ptb, 64'h0, 64'h0, verified ? ST_OK : ST_AUTH_FAIL,
                           pos + 1 >= msg_len);
            end
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_start(logic [63:0] nh, logic [39:0] nl, logic [15:0] al,
                                        logic [11:0] pl, logic [63:0] th, logic [63:0] tl);
        ccm_req_t r;
        r.op = OP_START;
        r.data = 8'($urandom);
        r.nonce_hi = nh;
        r.nonce_lo = nl;
        r.aad_len = al;
        r.pay_len = pl;
        r.rtag_hi = th;
        r.rtag_lo = tl;
        pending_reqs.push_back(r);
        n_items++;
    endfunction

    // fields other than the byte are don't-care here, so they get noise
    function automatic void queue_byte(op_t op, logic [7:0] b);
        ccm_req_t r;
        r.op = op;
        r.data = b;
        r.nonce_hi = rand64();
        r.nonce_lo = 40'(rand64());
        r.aad_len = 16'($urandom);
        r.pay_len = 12'($urandom);
        r.rtag_hi = rand64();
        r.rtag_lo = rand64();
        pending_reqs.push_back(r);
        n_items++;
    endfunction

    function automatic void queue_random_start();
        queue_start(rand64(), 40'(rand64()), 16'($urandom_range(3)), 12'($urandom_range(3)),
                    rand64(), rand64());
    endfunction

    // drops whatever run is open and leaves the block idle
    function automatic void queue_drop();
        queue_start(rand64(), 40'(rand64()), 16'($urandom_range(16'hffff, AAD_LEN_LIMIT)),
                    12'($urandom), rand64(), rand64());
    endfunction

    task automatic settle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_KEY0:     cfg_key[0] = v;
            CFG_KEY1:     cfg_key[1] = v;
            CFG_KEY2:     cfg_key[2] = v;
            CFG_KEY3:     cfg_key[3] = v;
            CFG_KEY_SIZE: cfg_key256 = v[0];
            CFG_DECRYPT:  cfg_decrypt = v[0];
            CFG_TAG_LEN:  cfg_tag_len = v[4:0];
            default:      cfg_nonce_len = v[3:0];
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_wdata <= rand64();
    endtask

    task automatic program_all(logic k256, logic dec, logic [4:0] tlen, logic [3:0] nlen);
        write_reg(CFG_KEY0, rand64());
        write_reg(CFG_KEY1, rand64());
        write_reg(CFG_KEY2, rand64());
        write_reg(CFG_KEY3, rand64());
        write_reg(CFG_KEY_SIZE, {rand64() & ~64'h1} | 64'(k256));
        write_reg(CFG_DECRYPT, {rand64() & ~64'h1} | 64'(dec));
        write_reg(CFG_TAG_LEN, 64'(tlen));
        write_reg(CFG_NONCE_LEN, 64'(nlen));
        close_writes();
    endtask

    // seal a message, then open it again with the same key, tag possibly corrupted
    task automatic run_pair(int al, int pl, bit noisy, bit full_release);
        logic [7:0] aad_bytes[$];
        logic [63:0] nh;
        logic [39:0] nl;
        logic [127:0] tgw;
        blk_t tg;
        int cut;
        nh = rand64();
        nl = 40'(rand64());
        sealed_ok = 1'b0;
        sealed_ct.delete();
        if (noisy) queue_byte(op_t'($urandom_range(3, 1)), 8'($urandom));
        queue_start(nh, nl, 16'(al), 12'(pl), rand64(), rand64());
        for (int k = 0; k < al; k++) begin
            if (noisy && k == 0) queue_byte(OP_PAYLOAD, 8'($urandom));
            aad_bytes.push_back(8'($urandom));
            queue_byte(OP_AAD, aad_bytes[k]);
        end
        for (int k = 0; k < pl; k++) begin
            if (noisy && k == 0) queue_byte(OP_AAD, 8'($urandom));
            queue_byte(OP_PAYLOAD, 8'($urandom));
        end
        settle();
        if (!sealed_ok) return;
        write_reg(CFG_DECRYPT, 64'h1);
        close_writes();
        tg = sealed_tag;
        for (int x = cfg_tag_len; x < 16; x++) tg[x] = 8'($urandom);
        if ($urandom_range(3) == 0) begin
            cut = $urandom_range(cfg_tag_len - 1);
            tg[cut] = tg[cut] ^ (8'h1 << $urandom_range(7));
        end
        tgw = tg;
        queue_start(nh, nl, 16'(al), 12'(pl), tgw[127:64], tgw[63:0]);
        foreach (aad_bytes[k]) queue_byte(OP_AAD, aad_bytes[k]);
        foreach (sealed_ct[k]) queue_byte(OP_PAYLOAD, sealed_ct[k]);
        if (pl > 0) begin
            cut = full_release ? pl : $urandom_range(pl - 1);
            for (int k = 0; k < cut; k++) queue_byte(OP_RELEASE, 8'($urandom));
            if (!full_release) queue_drop();
        end
        if (noisy) queue_byte(OP_RELEASE, 8'($urandom));
        settle();
        write_reg(CFG_DECRYPT, 64'h0);
        close_writes();
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_request(cur_req);
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= cur_req.op;
                    s_data_byte <= cur_req.data;
                    s_nonce_high <= cur_req.nonce_hi;
                    s_nonce_low <= cur_req.nonce_lo;
                    s_aad_length <= cur_req.aad_len;
                    s_payload_length <= cur_req.pay_len;
                    s_received_tag_high <= cur_req.rtag_hi;
                    s_received_tag_low <= cur_req.rtag_lo;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        ccm_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d byte=%h status=%0d last=%0b",
                             $time, m_result_kind, m_out_byte, m_status, m_last);
                    failures++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_result_kind !== e.kind || m_out_byte !== e.out_byte ||
                        m_tag_high !== e.tag_hi || m_tag_low !== e.tag_lo ||
                        m_status !== e.status || m_last !== e.last) begin
                        $display("%0t: expected kind=%0d byte=%h tag=%h%h status=%0d last=%0b",
                                 $time, e.kind, e.out_byte, e.tag_hi, e.tag_lo, e.status,
                                 e.last);
                        $display("%0t: actual   kind=%0d byte=%h tag=%h%h status=%0d last=%0b",
                                 $time, m_result_kind, m_out_byte, m_tag_high, m_tag_low,
                                 m_status, m_last);
                        failures++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= 22;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [4:0] tlen;
        logic [3:0] nlen;
        int iter;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_operation = '0;
        s_data_byte = '0;
        s_nonce_high = '0;
        s_nonce_low = '0;
        s_aad_length = '0;
        s_payload_length = '0;
        s_received_tag_high = '0;
        s_received_tag_low = '0;
        failures = 0;
        n_items = 0;
        stall_cycles = 0;
        calm = 1'b0;
        for (int k = 0; k < 4; k++) cfg_key[k] = '0;
        cfg_key256 = 1'b0;
        cfg_decrypt = 1'b0;
        cfg_tag_len = 5'd8;
        cfg_nonce_len = 4'd13;
        nrounds = 10;
        mac_acc = '0;
        blk_buf = '0;
        ks_blk = '0;
        rtag_store = '0;
        for (int k = 0; k < 13; k++) nonce_bytes[k] = '0;
        blk_fill = 0;
        ctr_idx = '0;
        aad_rem = 0;
        pay_rem = 0;
        msg_len = 0;
        rel_idx = '0;
        verified = 1'b0;
        msg_phase = PH_IDLE;
        lat_decrypt = 1'b0;
        lat_tag_len = 8;
        lat_nonce_len = 13;
        sealed_ok = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: out-of-order items, empty message, extremes
        queue_byte(OP_RELEASE, 8'h00);
        queue_byte(OP_AAD, 8'h5a);
        queue_byte(OP_PAYLOAD, 8'ha5);
        queue_start('1, '1, 16'd0, 12'd0, '1, '1);
        queue_start('0, '0, 16'd2, 12'd1, '0, '0);
        queue_byte(OP_AAD, 8'h00);
        queue_byte(OP_PAYLOAD, 8'hff);
        queue_byte(OP_AAD, 8'hff);
        queue_byte(OP_RELEASE, 8'hff);
        queue_byte(OP_PAYLOAD, 8'hff);
        queue_start(rand64(), 40'(rand64()), AAD_LEN_LIMIT, 12'd0, '0, '0);
        queue_start(rand64(), 40'(rand64()), 16'hffff, 12'hfff, '0, '0);
        queue_start(rand64(), 40'(rand64()), 16'd0, 12'(MAX_PAYLOAD + 1), '0, '0);
        queue_start(rand64(), 40'(rand64()), 16'd3, 12'd2, '0, '0);
        queue_byte(OP_AAD, 8'h11);
        queue_start(rand64(), 40'(rand64()), 16'd0, 12'd0, '0, '0);
        settle();

        // decryption with empty payload, then a short one with a bad tag
        program_all(1'b1, 1'b1, 5'd16, 4'd13);
        queue_start(rand64(), 40'(rand64()), 16'd0, 12'd0, rand64(), rand64());
        queue_start(rand64(), 40'(rand64()), 16'd1, 12'd2, rand64(), rand64());
        queue_byte(OP_AAD, 8'h80);
        queue_byte(OP_PAYLOAD, 8'h01);
        queue_byte(OP_PAYLOAD, 8'hfe);
        queue_byte(OP_RELEASE, 8'h00);
        queue_byte(OP_RELEASE, 8'h00);
        queue_byte(OP_RELEASE, 8'h00);
        settle();

        // bad tag and nonce lengths
        program_all(1'b0, 1'b0, 5'd3, 4'd13);
        queue_random_start();
        settle();
        program_all(1'b0, 1'b0, 5'd18, 4'd6);
        queue_random_start();
        settle();
        program_all(1'b1, 1'b0, 5'd4, 4'd14);
        queue_random_start();
        settle();

        iter = 0;
        while (n_items < 850) begin
            calm = (iter >= 4 && iter <= 6);
            if ($urandom_range(99) < 85) tlen = 5'(2 * $urandom_range(8, 2));
            else tlen = 5'($urandom_range(16));
            if ($urandom_range(99) < 90) nlen = 4'($urandom_range(13, 7));
            else nlen = 4'($urandom_range(15));
            program_all($urandom_range(1), 1'b0, tlen, nlen);
            if ($urandom_range(9) == 0) begin
                // broken sequences
                for (int k = 0; k < 20; k++) begin
                    if ($urandom_range(3) == 0) queue_random_start();
                    else queue_byte(op_t'($urandom_range(3, 1)), 8'($urandom));
                end
                queue_drop();
                settle();
            end else begin
                run_pair($urandom_range(3) == 0 ? $urandom_range(60, 25) : $urandom_range(24),
                         $urandom_range(40), $urandom_range(2) == 0, $urandom_range(4) != 0);
            end
            iter++;
        end
        calm = 1'b0;

        // one message at the largest payload
        program_all($urandom_range(1), 1'b0, 5'd16, 4'd7);
        run_pair(5, MAX_PAYLOAD, 1'b0, 1'b1);

        settle();
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
